// ===== rtl/tfnm_pkg.sv =====
// package for the triangle face neighbor matcher: sizes, codes, payload types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tfnm_pkg;
    localparam int MaxElems   = 4096;
    localparam int VertBits   = 16;
    localparam int EdgeSlots  = 16384;
    localparam int MaxProbes  = 8;
    localparam int FacesPer   = 3;
    localparam int ElemW      = $clog2(MaxElems);
    localparam int CountW     = ElemW + 1;
    localparam int SlotW      = $clog2(EdgeSlots);
    localparam int FaceSlots  = FacesPer * MaxElems;
    localparam int FaceW      = $clog2(FaceSlots);
    localparam int KeyW       = 2 * VertBits;
    localparam int OwnerW     = ElemW + 2;
    localparam int LinkW      = ElemW + 3;
    localparam int ProbeW     = $clog2(MaxProbes + 1);
    localparam logic [31:0] HashMul = 32'd2654435761;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StLost = 2'd1;
    localparam logic [1:0] StFull = 2'd2;

    localparam logic [1:0] UsedEmpty = 2'd0;
    localparam logic [1:0] UsedOne   = 2'd1;
    localparam logic [1:0] UsedPair  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] vert_a;
        logic [15:0] vert_b;
        logic [15:0] vert_c;
        logic [11:0] query_elem;
        logic [1:0]  query_face;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] neighbor_elem;
        logic [1:0]  neighbor_face;
        logic        is_boundary;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/tfnm_if.sv =====
// valid/ready channel carrying one payload beat
// depends on tfnm_pkg
`timescale 1ns / 1ps
`default_nettype none
interface tfnm_in_if;
    logic valid;
    logic ready;
    tfnm_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tfnm_out_if;
    logic valid;
    logic ready;
    tfnm_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tfnm_ram.sv =====
// generic simple dual port ram (separate write and read address), one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module tfnm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(Depth)-1:0] i_waddr,
    input  wire [Width-1:0]         i_wdata,
    input  wire [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]        o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/triangle_face_neighbor_matcher.sv =====
// triangle_face_neighbor_matcher: edge hash table and face neighbor store
// depends on tfnm_pkg, tfnm_if, tfnm_ram
//
// input channel: one beat is a load (func 0, three vertex ids) or a query
// (func 1, element and face). every beat yields exactly one result beat.
// a load gives the triangle the next element index and pairs its three
// faces through a linear-probed edge table; status 1 when a face found
// neither its key nor a free slot within the probe limit, status 2 when
// the element store is full. a query returns the neighbor element and face
// or the boundary flag, status 2 for an element not loaded or face 3.
// a load runs per face a hash state, then a probe read and a probe check
// for each probe, a second pair write when the face is paired, and a face
// step; a query reads the neighbor store, a rejected query skips the read
// and a load into a full store goes straight to output. the output state
// then raises valid. the edge and neighbor memories read registered, so
// every probe and query waits on its read. after reset both memories are
// cleared one entry a cycle while the input is not ready. one item is in
// work at a time; the result sits in the output register until taken, and
// the next item can be accepted in the cycle after that, back in idle.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_neighbor_matcher (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tfnm_in_if.sink       i_in,
    tfnm_out_if.source    o_out
);
    import tfnm_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_PROBE_RD, S_PROBE_CHK, S_LINK2,
        S_NEXT_FACE, S_Q_RD, S_Q_WAIT, S_Q_DONE, S_OUT
    } t_state;

    localparam int EntW = 2 + KeyW + OwnerW;

    t_state r_state;
    logic [SlotW-1:0] r_clr;
    logic [CountW-1:0] r_count;
    t_in r_item;
    logic [1:0] r_face;
    logic [ProbeW-1:0] r_probe;
    logic [SlotW-1:0] r_home;
    logic r_lost;
    logic [KeyW-1:0] r_key;
    logic [FaceW-1:0] r_own;
    logic [OwnerW-1:0] r_other;
    t_out r_res;
    logic r_valid;

    logic e_we;
    logic [SlotW-1:0] e_waddr, e_raddr;
    logic [EntW-1:0] e_wdata, e_rdata;
    logic f_we;
    logic [FaceW-1:0] f_waddr, f_raddr;
    logic [LinkW-1:0] f_wdata, f_rdata;

    tfnm_ram #(.Width(EntW), .Depth(EdgeSlots)) u_edge (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    tfnm_ram #(.Width(LinkW), .Depth(FaceSlots)) u_face (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    logic [VertBits-1:0] p, q, lo, hi;
    logic [1:0] e_used;
    logic [KeyW-1:0] e_key;
    logic [OwnerW-1:0] e_own;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] prod;
    logic [FaceW-1:0] own_idx;
    logic [FaceW+1:0] qidx;

    // owner entry holds element and face; own_idx is element * 3 + face
    always_comb begin
        unique case (r_face)
            2'd0: begin p = r_item.vert_a; q = r_item.vert_b; end
            2'd1: begin p = r_item.vert_b; q = r_item.vert_c; end
            default: begin p = r_item.vert_c; q = r_item.vert_a; end
        endcase
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        prod = SlotW'(hi) * HashMul[SlotW-1:0] + SlotW'(lo);
        {e_used, e_key, e_own} = e_rdata;
        slot = r_home + SlotW'(r_probe);
        own_idx = FaceW'({e_own[OwnerW-1:2], 1'b0}) + FaceW'(e_own[OwnerW-1:2])
                + FaceW'(e_own[1:0]);
        qidx = (FaceW+2)'(r_item.query_elem) * (FaceW+2)'(FacesPer)
             + (FaceW+2)'(r_item.query_face);
    end

    always_comb begin
        e_we = 1'b0; e_waddr = slot; e_raddr = slot; e_wdata = '0;
        f_we = 1'b0; f_waddr = r_own; f_raddr = FaceW'(qidx); f_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                e_we = 1'b1; e_waddr = r_clr;
                f_we = (32'(r_clr) < FaceSlots); f_waddr = FaceW'(r_clr);
            end
            S_PROBE_CHK: begin
                if (e_used == UsedEmpty) begin
                    e_we = 1'b1;
                    e_wdata = {UsedOne, r_key, r_count[ElemW-1:0], r_face};
                end else if (e_key == r_key && e_used == UsedOne) begin
                    e_we = 1'b1; e_wdata = {UsedPair, e_key, e_own};
                    f_we = 1'b1; f_waddr = own_idx;
                    f_wdata = {r_count[ElemW-1:0], r_face, 1'b1};
                end
            end
            S_LINK2: begin
                f_we = 1'b1; f_waddr = r_own;
                f_wdata = {r_other, 1'b1};
            end
            default: ;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_valid;
    assign o_out.data = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SlotW'(EdgeSlots - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item <= i_in.data;
                        r_face <= 2'd0;
                        r_lost <= 1'b0;
                        if (i_in.data.func) begin
                            r_res <= '0;
                            r_state <= S_Q_RD;
                        end else if (32'(r_count) >= MaxElems) begin
                            r_res <= t_out'{status: StFull, default: '0};
                            r_state <= S_OUT;
                        end else begin
                            r_res <= '0;
                            r_state <= S_HASH;
                        end
                    end
                end
                S_HASH: begin
                    r_key <= {hi, lo};
                    r_home <= prod;
                    r_probe <= '0;
                    r_own <= FaceW'(32'(r_count[ElemW-1:0]) * FacesPer + 32'(r_face));
                    r_state <= S_PROBE_RD;
                end
                S_PROBE_RD: r_state <= S_PROBE_CHK;
                S_PROBE_CHK: begin
                    if (e_used == UsedEmpty) begin
                        r_state <= S_NEXT_FACE;
                    end else if (e_key == r_key) begin
                        r_other <= e_own;
                        r_state <= (e_used == UsedOne) ? S_LINK2 : S_NEXT_FACE;
                    end else if (32'(r_probe) == MaxProbes - 1) begin
                        r_lost <= 1'b1;
                        r_state <= S_NEXT_FACE;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                        r_state <= S_PROBE_RD;
                    end
                end
                S_LINK2: r_state <= S_NEXT_FACE;
                S_NEXT_FACE: begin
                    if (r_face == 2'd2) begin
                        r_count <= r_count + 1'b1;
                        r_res.status <= r_lost ? StLost : StOk;
                        r_state <= S_OUT;
                    end else begin
                        r_face <= r_face + 1'b1;
                        r_state <= S_HASH;
                    end
                end
                S_Q_RD: begin
                    if (13'(r_item.query_elem) >= 13'(r_count)
                            || r_item.query_face == 2'd3) begin
                        r_res.status <= StFull;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_Q_WAIT;
                    end
                end
                S_Q_WAIT: r_state <= S_Q_DONE;
                S_Q_DONE: begin
                    if (f_rdata[0]) begin
                        r_res.neighbor_elem <= f_rdata[LinkW-1:3];
                        r_res.neighbor_face <= f_rdata[2:1];
                    end else begin
                        r_res.is_boundary <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (o_out.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== bench/triangle_face_neighbor_matcher_tb.sv =====
// testbench for triangle_face_neighbor_matcher: directed and random loads and queries
// depends on tfnm_pkg, tfnm_if and the block; predicts each result beat and compares it
`timescale 1ns / 1ps
module triangle_face_neighbor_matcher_tb;
    import tfnm_pkg::*;

    logic i_clk;
    logic i_rst_n;

    tfnm_in_if  in_ch ();
    tfnm_out_if out_ch ();

    triangle_face_neighbor_matcher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // predictor state
    logic [31:0] slot_key   [EdgeSlots];
    logic [1:0]  slot_used  [EdgeSlots];
    int          slot_owner [EdgeSlots];
    logic [14:0] nbr_link   [FaceSlots];
    int          loaded;

    t_out result_q[$];
    int   errors;
    int   send_idle;
    int   recv_idle;

    function automatic bit seat_face(logic [15:0] lo, logic [15:0] hi, int elem, int face);
        logic [31:0] key;
        logic [63:0] home;
        int s;
        int own;
        key  = {hi, lo};
        home = (64'(lo) + 64'(hi) * 64'd2654435761) % EdgeSlots;
        for (int i = 0; i < MaxProbes; i++) begin
            s = int'((home + i) % EdgeSlots);
            if (slot_used[s] == UsedEmpty) begin
                slot_used[s]  = UsedOne;
                slot_key[s]   = key;
                slot_owner[s] = elem * FacesPer + face;
                return 1'b1;
            end
            if (slot_key[s] == key) begin
                if (slot_used[s] == UsedOne) begin
                    own = slot_owner[s];
                    nbr_link[own] = {12'(elem), 2'(face), 1'b1};
                    nbr_link[elem * FacesPer + face] =
                        {12'(own / FacesPer), 2'(own % FacesPer), 1'b1};
                    slot_used[s] = UsedPair;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out predict_neighbor(t_in it);
        t_out r;
        logic [15:0] v[3];
        logic [15:0] p, q;
        bit lost;
        r = '0;
        if (it.func == 1'b0) begin
            if (loaded >= MaxElems) begin
                r.status = StFull;
                return r;
            end
            v[0] = it.vert_a;
            v[1] = it.vert_b;
            v[2] = it.vert_c;
            lost = 1'b0;
            for (int f = 0; f < FacesPer; f++) begin
                p = v[f];
                q = v[(f + 1) % 3];
                if (!seat_face(p < q ? p : q, p < q ? q : p, loaded, f))
                    lost = 1'b1;
            end
            loaded++;
            r.status = lost ? StLost : StOk;
        end else begin
            if (int'(it.query_elem) >= loaded || it.query_face >= FacesPer) begin
                r.status = StFull;
                return r;
            end
            if (nbr_link[it.query_elem * FacesPer + it.query_face][0]) begin
                r.neighbor_elem = nbr_link[it.query_elem * FacesPer + it.query_face][14:3];
                r.neighbor_face = nbr_link[it.query_elem * FacesPer + it.query_face][2:1];
            end else begin
                r.is_boundary = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_beat(t_in it);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        result_q.push_back(predict_neighbor(it));
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_load(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        t_in it;
        it = '0;
        it.func = 1'b0;
        it.vert_a = a;
        it.vert_b = b;
        it.vert_c = c;
        it.query_elem = 12'($urandom);
        it.query_face = 2'($urandom);
        send_beat(it);
    endtask

    task automatic send_query(logic [11:0] e, logic [1:0] f);
        t_in it;
        it = '0;
        it.func = 1'b1;
        it.query_elem = e;
        it.query_face = f;
        it.vert_a = 16'($urandom);
        it.vert_b = 16'($urandom);
        it.vert_c = 16'($urandom);
        send_beat(it);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected beat %p", $time, out_ch.data);
                    errors++;
                end else begin
                    if (out_ch.data.status !== result_q[0].status)
                        $display("%0t: status exp %0d got %0d", $time,
                                 result_q[0].status, out_ch.data.status);
                    if (out_ch.data.neighbor_elem !== result_q[0].neighbor_elem)
                        $display("%0t: neighbor_elem exp %0d got %0d", $time,
                                 result_q[0].neighbor_elem, out_ch.data.neighbor_elem);
                    if (out_ch.data.neighbor_face !== result_q[0].neighbor_face)
                        $display("%0t: neighbor_face exp %0d got %0d", $time,
                                 result_q[0].neighbor_face, out_ch.data.neighbor_face);
                    if (out_ch.data.is_boundary !== result_q[0].is_boundary)
                        $display("%0t: is_boundary exp %0d got %0d", $time,
                                 result_q[0].is_boundary, out_ch.data.is_boundary);
                    if (out_ch.data !== result_q[0]) errors++;
                    void'(result_q.pop_front());
                end
            end
        end
    end

    task automatic test_directed();
        send_query(12'd0, 2'd0);
        send_load(16'd1, 16'd2, 16'd3);
        send_load(16'd3, 16'd2, 16'd4);
        send_load(16'd2, 16'd3, 16'd5);
        send_load(16'hFFFF, 16'h0000, 16'h8000);
        send_load(16'd7, 16'd7, 16'd9);
        send_load(16'd10, 16'd10, 16'd10);
        for (int e = 0; e < 7; e++)
            for (int f = 0; f < 4; f++)
                if (e < 2 || f == 3 || e >= 4) send_query(12'(e), 2'(f));
        send_query(12'hFFF, 2'd1);
    endtask

    // many vertex pairs with one home slot, so probing runs out
    task automatic test_probe_exhaust();
        int hv;
        for (int k = 0; k < 10; k++) begin
            hv = 20000 + k;
            send_load(16'((100 - hv * int'(HashMul[SlotW-1:0])) & (EdgeSlots - 1)),
                      16'(hv), 16'(60000 + k));
        end
        for (int k = 0; k < 10; k++) send_query(12'(loaded - 1 - k), 2'($urandom_range(2)));
    endtask

    task automatic test_random_mesh(int n);
        logic [15:0] base;
        for (int i = 0; i < n; i++) begin
            base = 16'($urandom_range(60));
            case ($urandom_range(9))
                0: send_load(16'($urandom), 16'($urandom), 16'($urandom));
                1, 2, 3: send_query(12'($urandom_range(loaded + 2)), 2'($urandom));
                4: send_query(12'($urandom), 2'($urandom));
                default: send_load(base, 16'(base + $urandom_range(1, 3)),
                                   16'(base + $urandom_range(4, 6)));
            endcase
        end
    endtask

    task automatic drain();
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        loaded = 0;
        for (int i = 0; i < EdgeSlots; i++) slot_used[i] = UsedEmpty;
        for (int i = 0; i < FaceSlots; i++) nbr_link[i] = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        send_idle = 13;
        recv_idle = 69;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_probe_exhaust();
        test_random_mesh(180);
        send_idle = 69;
        recv_idle = 13;
        test_random_mesh(180);
        send_idle = 0;
        recv_idle = 0;
        test_random_mesh(160);
        drain();
        if (errors == 0 && result_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
